// ===== hdl/nnfs_pkg.sv =====
// shared constants, codes and helpers for the letterbox scaler
`default_nettype none
package nnfs_pkg;

  localparam int MAX_IMAGE_WIDTH_DEF  = 256;
  localparam int MAX_IMAGE_HEIGHT_DEF = 256;
  localparam int MAX_FRAME_DIM_DEF    = 4096;

  localparam int COORD_W     = 12;
  localparam int PIXEL_W     = 32;
  localparam int FRAME_CFG_W = 13;
  localparam int IMAGE_CFG_W = 9;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 3;

  localparam logic [FRAME_CFG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [FRAME_CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;
  localparam logic [IMAGE_CFG_W-1:0] IMAGE_WIDTH_RST  = 9'd256;
  localparam logic [IMAGE_CFG_W-1:0] IMAGE_HEIGHT_RST = 9'd256;
  localparam logic [PIXEL_W-1:0]     BACKGROUND_RST   = 32'hFF0F1116;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_IMAGE_WIDTH  = 3'd2,
    CFG_IMAGE_HEIGHT = 3'd3,
    CFG_BACKGROUND   = 3'd4
  } cfg_index_t;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  function automatic int max2(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/nnfs_in_if.sv =====
// request channel: pixel writes and frame reads
`default_nettype none
interface nnfs_in_if;
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [nnfs_pkg::COORD_W-1:0] coord_x;
  logic [nnfs_pkg::COORD_W-1:0] coord_y;
  logic [nnfs_pkg::PIXEL_W-1:0] pixel_in;

  modport source (output valid, operation, coord_x, coord_y, pixel_in, input ready);
  modport sink   (input valid, operation, coord_x, coord_y, pixel_in, output ready);
endinterface
`default_nettype wire

// ===== hdl/nnfs_out_if.sv =====
// result channel: frame pixels
`default_nettype none
interface nnfs_out_if;
  logic                         valid;
  logic                         ready;
  logic [nnfs_pkg::PIXEL_W-1:0] pixel_out;
  logic                         from_image;

  modport source (output valid, pixel_out, from_image, input ready);
  modport sink   (input valid, pixel_out, from_image, output ready);
endinterface
`default_nettype wire

// ===== hdl/nearest_neighbor_fit_scaler_core.sv =====
// Nearest neighbour letterbox scaler: source image store and frame pixel pipeline.
//
// in_s carries words: operation 0 writes pixel_in at source (coord_x, coord_y),
// ignored outside the configured image size; operation 1 reads the frame pixel
// at (coord_x, coord_y) and yields one word on out_s. Writes yield nothing.
// Throughput is one word per cycle while out_s accepts and the window is not
// being recomputed. A read passes the input register, window check and
// multiply, QW one-bit divider stages for the source column and row (QW =
// clog2 of the larger maximum image side, 8 by default), the store read, and
// the output register. Writes take effect in request order with reads through
// the same pipeline. cfg_we/cfg_index/cfg_wdata write a register. After reset
// and after every register write the display window is recomputed by a shared
// serial divider; in_s.ready stays low meanwhile. The store has no reset and
// must be written before it is read. When out_s stalls the stages fill up in
// turn and in_s.ready drops only once every stage holds a word.
`default_nettype none
module nearest_neighbor_fit_scaler_core #(
  parameter int MAX_IMAGE_WIDTH  = nnfs_pkg::MAX_IMAGE_WIDTH_DEF,
  parameter int MAX_IMAGE_HEIGHT = nnfs_pkg::MAX_IMAGE_HEIGHT_DEF,
  parameter int MAX_FRAME_DIM    = nnfs_pkg::MAX_FRAME_DIM_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  nnfs_in_if.sink                               in_s,
  nnfs_out_if.source                            out_s,
  input  wire logic                             cfg_we,
  input  wire logic [nnfs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [nnfs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int IW_W  = $clog2(MAX_IMAGE_WIDTH + 1);
  localparam int IH_W  = $clog2(MAX_IMAGE_HEIGHT + 1);
  localparam int FW_W  = $clog2(MAX_FRAME_DIM + 1);
  localparam int QW    = nnfs_pkg::max2($clog2(MAX_IMAGE_WIDTH), $clog2(MAX_IMAGE_HEIGHT));
  localparam int CW    = nnfs_pkg::max2(FW_W, nnfs_pkg::COORD_W) + 1;
  localparam int NW    = nnfs_pkg::max2(nnfs_pkg::max2(FW_W + IW_W, FW_W + IH_W), FW_W + QW);
  localparam int DEPTH = MAX_IMAGE_WIDTH * MAX_IMAGE_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int NS    = QW + 3;
  localparam int RS    = NS - 1;

  typedef struct packed {
    logic                         rd;
    logic                         wr;
    logic                         win;
    logic [nnfs_pkg::COORD_W-1:0] cx;
    logic [nnfs_pkg::COORD_W-1:0] cy;
    logic [nnfs_pkg::PIXEL_W-1:0] pix;
    logic [AW-1:0]                waddr;
    logic [NW-1:0]                rx;
    logic [NW-1:0]                ry;
    logic [QW-1:0]                qx;
    logic [QW-1:0]                qy;
  } stage_t;

  logic                         busy;
  logic [FW_W-1:0]              sw, sh, lm, tm;
  logic [IW_W-1:0]              iw;
  logic [IH_W-1:0]              ih;
  logic [nnfs_pkg::PIXEL_W-1:0] bg;

  stage_t                       st_r   [NS];
  stage_t                       st_nxt [NS];
  logic [NS-1:0]                v_r;
  logic [NS:0]                  rdy;
  logic                         acc;

  logic                         out_v_r;
  logic [nnfs_pkg::PIXEL_W-1:0] out_pix_r;
  logic                         out_from_r;

  logic                         ram_we, ram_re;
  logic [AW-1:0]                ram_raddr;
  logic [nnfs_pkg::PIXEL_W-1:0] ram_rdata;

  nnfs_geom #(
    .MAX_IMAGE_WIDTH  (MAX_IMAGE_WIDTH),
    .MAX_IMAGE_HEIGHT (MAX_IMAGE_HEIGHT),
    .MAX_FRAME_DIM    (MAX_FRAME_DIM)
  ) u_geom (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .busy       (busy),
    .shown_w    (sw),
    .shown_h    (sh),
    .left_m     (lm),
    .top_m      (tm),
    .img_w      (iw),
    .img_h      (ih),
    .background (bg)
  );

  // per-stage ready: a stage may load when empty or when it moves on
  always_comb begin
    rdy[NS] = !out_v_r || out_s.ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_s.ready = rdy[0] && !busy;
  assign acc        = in_s.valid && in_s.ready;

  always_comb begin
    st_nxt[0]     = '0;
    st_nxt[0].rd  = in_s.operation == nnfs_pkg::OP_READ;
    st_nxt[0].cx  = in_s.coord_x;
    st_nxt[0].cy  = in_s.coord_y;
    st_nxt[0].pix = in_s.pixel_in;
  end

  // window check, offsets into the window and numerators for the divide
  always_comb begin
    logic [CW-1:0] xe, ye, dxe, dye;
    logic          inx, iny;
    xe  = CW'(st_r[0].cx);
    ye  = CW'(st_r[0].cy);
    dxe = xe - CW'(lm);
    dye = ye - CW'(tm);
    inx = (xe >= CW'(lm)) && (dxe < CW'(sw));
    iny = (ye >= CW'(tm)) && (dye < CW'(sh));
    st_nxt[1]       = st_r[0];
    st_nxt[1].win   = st_r[0].rd && inx && iny;
    st_nxt[1].wr    = !st_r[0].rd && (xe < CW'(iw)) && (ye < CW'(ih));
    st_nxt[1].waddr = AW'(32'(st_r[0].cy) * 32'(MAX_IMAGE_WIDTH) + 32'(st_r[0].cx));
    st_nxt[1].rx    = NW'(dxe[FW_W-1:0]) * NW'(iw);
    st_nxt[1].ry    = NW'(dye[FW_W-1:0]) * NW'(ih);
    st_nxt[1].qx    = '0;
    st_nxt[1].qy    = '0;
  end

  // one quotient bit per stage, msb first
  for (genvar k = 2; k <= QW + 1; k++) begin : g_div
    localparam int B = QW + 1 - k;
    always_comb begin
      st_nxt[k] = st_r[k-1];
      if (st_r[k-1].rx >= (NW'(sw) << B)) begin
        st_nxt[k].rx    = st_r[k-1].rx - (NW'(sw) << B);
        st_nxt[k].qx[B] = 1'b1;
      end
      if (st_r[k-1].ry >= (NW'(sh) << B)) begin
        st_nxt[k].ry    = st_r[k-1].ry - (NW'(sh) << B);
        st_nxt[k].qy[B] = 1'b1;
      end
    end
  end

  assign st_nxt[RS] = st_r[RS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= acc;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
      if (rdy[NS]) begin
        out_v_r <= v_r[RS] && st_r[RS].rd;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (rdy[k]) begin
        st_r[k] <= st_nxt[k];
      end
    end
    if (rdy[NS]) begin
      out_pix_r  <= st_r[RS].win ? ram_rdata : bg;
      out_from_r <= st_r[RS].win;
    end
  end

  // store access as a word enters the last stage
  assign ram_we    = rdy[RS] && v_r[RS-1] && st_r[RS-1].wr;
  assign ram_re    = rdy[RS] && v_r[RS-1] && st_r[RS-1].rd;
  assign ram_raddr = AW'(32'(st_r[RS-1].qy) * 32'(MAX_IMAGE_WIDTH) + 32'(st_r[RS-1].qx));

  nnfs_ram #(
    .WIDTH (nnfs_pkg::PIXEL_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (st_r[RS-1].waddr),
    .wdata (st_r[RS-1].pix),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_s.valid      = out_v_r;
  assign out_s.pixel_out  = out_pix_r;
  assign out_s.from_image = out_from_r;

  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("store written and read in the same cycle");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(v_r[RS]))
    else $error("result appeared without a word in the store stage");

  a_image_window: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_from_r) |-> (sw != '0 && sh != '0))
    else $error("image pixel returned with an empty display window");

endmodule
`default_nettype wire

// ===== hdl/nnfs_ram.sv =====
// generic simple dual port ram with registered read
`default_nettype none
module nnfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/nnfs_geom.sv =====
// configuration registers and sequential display window computation
`default_nettype none
module nnfs_geom #(
  parameter int MAX_IMAGE_WIDTH  = nnfs_pkg::MAX_IMAGE_WIDTH_DEF,
  parameter int MAX_IMAGE_HEIGHT = nnfs_pkg::MAX_IMAGE_HEIGHT_DEF,
  parameter int MAX_FRAME_DIM    = nnfs_pkg::MAX_FRAME_DIM_DEF,
  localparam int IW_W = $clog2(MAX_IMAGE_WIDTH + 1),
  localparam int IH_W = $clog2(MAX_IMAGE_HEIGHT + 1),
  localparam int FW_W = $clog2(MAX_FRAME_DIM + 1)
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [nnfs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [nnfs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output logic                                  busy,
  output logic      [FW_W-1:0]                  shown_w,
  output logic      [FW_W-1:0]                  shown_h,
  output logic      [FW_W-1:0]                  left_m,
  output logic      [FW_W-1:0]                  top_m,
  output logic      [IW_W-1:0]                  img_w,
  output logic      [IH_W-1:0]                  img_h,
  output logic      [nnfs_pkg::PIXEL_W-1:0]     background
);

  localparam int IMW   = nnfs_pkg::max2(IW_W, IH_W);
  localparam int PW    = FW_W + IMW;
  localparam int CNT_W = $clog2(PW);

  typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_CMP, ST_DIV, ST_FIN} state_t;

  state_t                               state_r;
  logic [nnfs_pkg::FRAME_CFG_W-1:0]     fw_cfg_r, fh_cfg_r;
  logic [nnfs_pkg::IMAGE_CFG_W-1:0]     iw_cfg_r, ih_cfg_r;
  logic [nnfs_pkg::PIXEL_W-1:0]         bg_r;
  logic [PW-1:0]                        pa_r, pb_r, num_r;
  logic [IMW-1:0]                       dvs_r, rem_r;
  logic                                 wlim_r;
  logic [CNT_W-1:0]                     cnt_r;
  logic [FW_W-1:0]                      sw_r, sh_r, lm_r, tm_r;

  logic [FW_W-1:0] fw, fh, qw, qh;
  logic [IW_W-1:0] iw;
  logic [IH_W-1:0] ih;
  logic [IMW:0]    tr;
  logic            ge;
  logic [IMW-1:0]  rem_nxt;
  logic            cfg_hit;

  // clamped register values
  always_comb begin
    if (fw_cfg_r == '0) fw = FW_W'(1);
    else if (32'(fw_cfg_r) > 32'(MAX_FRAME_DIM)) fw = FW_W'(MAX_FRAME_DIM);
    else fw = FW_W'(fw_cfg_r);
    if (fh_cfg_r == '0) fh = FW_W'(1);
    else if (32'(fh_cfg_r) > 32'(MAX_FRAME_DIM)) fh = FW_W'(MAX_FRAME_DIM);
    else fh = FW_W'(fh_cfg_r);
    if (32'(iw_cfg_r) > 32'(MAX_IMAGE_WIDTH)) iw = IW_W'(MAX_IMAGE_WIDTH);
    else iw = IW_W'(iw_cfg_r);
    if (32'(ih_cfg_r) > 32'(MAX_IMAGE_HEIGHT)) ih = IH_W'(MAX_IMAGE_HEIGHT);
    else ih = IH_W'(ih_cfg_r);
  end

  // one restoring division step, quotient shifts into num_r
  always_comb begin
    tr      = {rem_r, num_r[PW-1]};
    ge      = tr >= {1'b0, dvs_r};
    rem_nxt = ge ? IMW'(tr - {1'b0, dvs_r}) : IMW'(tr);
  end

  // scaled side clamped to 1..frame
  always_comb begin
    if (num_r == '0) qh = FW_W'(1);
    else if (num_r > PW'(fh)) qh = fh;
    else qh = FW_W'(num_r);
    if (num_r == '0) qw = FW_W'(1);
    else if (num_r > PW'(fw)) qw = fw;
    else qw = FW_W'(num_r);
  end

  assign cfg_hit = cfg_we && (cfg_index == nnfs_pkg::CFG_FRAME_WIDTH ||
                              cfg_index == nnfs_pkg::CFG_FRAME_HEIGHT ||
                              cfg_index == nnfs_pkg::CFG_IMAGE_WIDTH ||
                              cfg_index == nnfs_pkg::CFG_IMAGE_HEIGHT ||
                              cfg_index == nnfs_pkg::CFG_BACKGROUND);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_MUL;
      fw_cfg_r <= nnfs_pkg::FRAME_WIDTH_RST;
      fh_cfg_r <= nnfs_pkg::FRAME_HEIGHT_RST;
      iw_cfg_r <= nnfs_pkg::IMAGE_WIDTH_RST;
      ih_cfg_r <= nnfs_pkg::IMAGE_HEIGHT_RST;
      bg_r     <= nnfs_pkg::BACKGROUND_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        nnfs_pkg::CFG_FRAME_WIDTH:  fw_cfg_r <= cfg_wdata[nnfs_pkg::FRAME_CFG_W-1:0];
        nnfs_pkg::CFG_FRAME_HEIGHT: fh_cfg_r <= cfg_wdata[nnfs_pkg::FRAME_CFG_W-1:0];
        nnfs_pkg::CFG_IMAGE_WIDTH:  iw_cfg_r <= cfg_wdata[nnfs_pkg::IMAGE_CFG_W-1:0];
        nnfs_pkg::CFG_IMAGE_HEIGHT: ih_cfg_r <= cfg_wdata[nnfs_pkg::IMAGE_CFG_W-1:0];
        nnfs_pkg::CFG_BACKGROUND:   bg_r     <= cfg_wdata[nnfs_pkg::PIXEL_W-1:0];
        default: ;
      endcase
      if (cfg_hit) begin
        state_r <= ST_MUL;
      end
    end else begin
      unique case (state_r)
        ST_IDLE: ;
        ST_MUL: begin
          if (iw == '0 || ih == '0) begin
            sw_r    <= '0;
            sh_r    <= '0;
            lm_r    <= '0;
            tm_r    <= '0;
            state_r <= ST_IDLE;
          end else begin
            pa_r    <= PW'(fw) * PW'(ih);
            pb_r    <= PW'(fh) * PW'(iw);
            state_r <= ST_CMP;
          end
        end
        ST_CMP: begin
          // width limits when fw*ih <= fh*iw, numerator is that same product
          wlim_r  <= pa_r <= pb_r;
          num_r   <= (pa_r <= pb_r) ? pa_r : pb_r;
          dvs_r   <= (pa_r <= pb_r) ? IMW'(iw) : IMW'(ih);
          rem_r   <= '0;
          cnt_r   <= CNT_W'(PW - 1);
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          rem_r <= rem_nxt;
          num_r <= {num_r[PW-2:0], ge};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (wlim_r) begin
            sw_r <= fw;
            sh_r <= qh;
            lm_r <= '0;
            tm_r <= FW_W'((fh - qh) >> 1);
          end else begin
            sw_r <= qw;
            sh_r <= fh;
            lm_r <= FW_W'((fw - qw) >> 1);
            tm_r <= '0;
          end
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy       = state_r != ST_IDLE;
  assign shown_w    = sw_r;
  assign shown_h    = sh_r;
  assign left_m     = lm_r;
  assign top_m      = tm_r;
  assign img_w      = iw;
  assign img_h      = ih;
  assign background = bg_r;

  a_cfg_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> busy)
    else $error("register write did not restart window computation");

  a_window_fits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> (sw_r <= fw && sh_r <= fh))
    else $error("display window larger than frame");

  a_window_pair: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> ((sw_r == '0) == (sh_r == '0)))
    else $error("display window has one empty side");

endmodule
`default_nettype wire

// ===== tb/nnfs_scaler_checker.sv =====
// scoreboard for the letterbox scaler: mirrors the image store and window, checks frame pixels
`timescale 1ns / 100ps
`default_nettype none
module nnfs_scaler_checker (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  nnfs_in_if                                    req_mon,
  nnfs_out_if                                   px_mon,
  input  wire logic                             cfg_we,
  input  wire logic [nnfs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [nnfs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output int                                    fail_count,
  output int                                    reads_in_flight
);

  localparam int STORE_W = nnfs_pkg::MAX_IMAGE_WIDTH_DEF;

  typedef struct packed {
    logic [nnfs_pkg::PIXEL_W-1:0] pixel;
    logic                         from_image;
  } frame_px_t;

  logic [nnfs_pkg::FRAME_CFG_W-1:0] frame_w, frame_h;
  logic [nnfs_pkg::IMAGE_CFG_W-1:0] image_w, image_h;
  logic [nnfs_pkg::PIXEL_W-1:0]     bg_color;
  logic [nnfs_pkg::PIXEL_W-1:0]
    image_pix [0:nnfs_pkg::MAX_IMAGE_WIDTH_DEF*nnfs_pkg::MAX_IMAGE_HEIGHT_DEF-1];
  frame_px_t                        frame_px_q [$];

  function automatic longint eff_image(input longint v, input longint lim);
    return (v > lim) ? lim : v;
  endfunction

  // exact rational fit of the image into the frame, then nearest source pixel
  function automatic frame_px_t frame_pixel(input logic [nnfs_pkg::COORD_W-1:0] x,
                                            input logic [nnfs_pkg::COORD_W-1:0] y);
    longint fw, fh, iw, ih, dw, dh, lm, tm;
    frame_px_t r;
    fw = (frame_w == 0) ? 1 : eff_image(frame_w, nnfs_pkg::MAX_FRAME_DIM_DEF);
    fh = (frame_h == 0) ? 1 : eff_image(frame_h, nnfs_pkg::MAX_FRAME_DIM_DEF);
    iw = eff_image(image_w, nnfs_pkg::MAX_IMAGE_WIDTH_DEF);
    ih = eff_image(image_h, nnfs_pkg::MAX_IMAGE_HEIGHT_DEF);
    r.pixel = bg_color;
    r.from_image = 1'b0;
    if (iw == 0 || ih == 0) return r;
    if (fw * ih <= fh * iw) begin
      dw = fw;
      dh = (ih * fw) / iw;
    end else begin
      dw = (iw * fh) / ih;
      dh = fh;
    end
    if (dw == 0) dw = 1;
    if (dh == 0) dh = 1;
    if (dw > fw) dw = fw;
    if (dh > fh) dh = fh;
    lm = (fw - dw) / 2;
    tm = (fh - dh) / 2;
    if (x >= lm && x - lm < dw && y >= tm && y - tm < dh) begin
      r.pixel = image_pix[((y - tm) * ih / dh) * STORE_W + (x - lm) * iw / dw];
      r.from_image = 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    frame_px_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      frame_w  <= nnfs_pkg::FRAME_WIDTH_RST;
      frame_h  <= nnfs_pkg::FRAME_HEIGHT_RST;
      image_w  <= nnfs_pkg::IMAGE_WIDTH_RST;
      image_h  <= nnfs_pkg::IMAGE_HEIGHT_RST;
      bg_color <= nnfs_pkg::BACKGROUND_RST;
      frame_px_q.delete();
    end else begin
      if (req_mon.valid && req_mon.ready) begin
        if (nnfs_pkg::op_t'(req_mon.operation) == nnfs_pkg::OP_READ) begin
          frame_px_q.push_back(frame_pixel(req_mon.coord_x, req_mon.coord_y));
        end else if (req_mon.coord_x < eff_image(image_w, nnfs_pkg::MAX_IMAGE_WIDTH_DEF) &&
                     req_mon.coord_y < eff_image(image_h, nnfs_pkg::MAX_IMAGE_HEIGHT_DEF)) begin
          image_pix[req_mon.coord_y * STORE_W + req_mon.coord_x] = req_mon.pixel_in;
        end
      end
      if (px_mon.valid && px_mon.ready) begin
        if (frame_px_q.size() == 0) begin
          errs++;
          $display("%0t: unexpected frame word pixel %h from_image %b", $time,
                   px_mon.pixel_out, px_mon.from_image);
        end else begin
          want = frame_px_q.pop_front();
          if (px_mon.pixel_out !== want.pixel) begin
            errs++;
            $display("%0t: pixel_out expected %h actual %h", $time, want.pixel,
                     px_mon.pixel_out);
          end
          if (px_mon.from_image !== want.from_image) begin
            errs++;
            $display("%0t: from_image expected %b actual %b", $time, want.from_image,
                     px_mon.from_image);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          nnfs_pkg::CFG_FRAME_WIDTH:  frame_w  <= cfg_wdata[nnfs_pkg::FRAME_CFG_W-1:0];
          nnfs_pkg::CFG_FRAME_HEIGHT: frame_h  <= cfg_wdata[nnfs_pkg::FRAME_CFG_W-1:0];
          nnfs_pkg::CFG_IMAGE_WIDTH:  image_w  <= cfg_wdata[nnfs_pkg::IMAGE_CFG_W-1:0];
          nnfs_pkg::CFG_IMAGE_HEIGHT: image_h  <= cfg_wdata[nnfs_pkg::IMAGE_CFG_W-1:0];
          nnfs_pkg::CFG_BACKGROUND:   bg_color <= cfg_wdata;
          default: ;
        endcase
      end
    end
    if (errs != 0) begin
      fail_count <= fail_count + errs;
    end
    reads_in_flight <= frame_px_q.size();
  end

  initial fail_count = 0;
endmodule
`default_nettype wire

// ===== tb/nearest_neighbor_fit_scaler_core_tb.sv =====
// top of the scaler testbench: clock, reset, request and config stimulus, verdict
`timescale 1ns / 100ps
`default_nettype none
module nearest_neighbor_fit_scaler_core_tb;

  localparam logic [nnfs_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_IDX = 3'd7;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 30;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [nnfs_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [nnfs_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;
  int fail_count, reads_in_flight;
  int stall_cycles = 0;
  int frames_seen = 0;
  int hold_left = 0;
  bit held_once = 0;
  bit steady_src = 0;
  bit steady_sink = 0;

  nnfs_in_if  req_ch ();
  nnfs_out_if px_ch ();

  nearest_neighbor_fit_scaler_core dut (
    .clk(clk), .rst_n(rst_n), .in_s(req_ch.sink), .out_s(px_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  nnfs_scaler_checker scoreboard (
    .clk(clk), .rst_n(rst_n), .req_mon(req_ch), .px_mon(px_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .reads_in_flight(reads_in_flight)
  );

  always #1 clk = ~clk;

  initial begin
    req_ch.valid = 1'b0;
    req_ch.operation = nnfs_pkg::OP_WRITE;
    req_ch.coord_x = '0;
    req_ch.coord_y = '0;
    req_ch.pixel_in = '0;
    px_ch.ready = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // result side: random back-pressure, plus one long hold to fill the pipeline
  always @(negedge clk) begin
    if (px_ch.valid && px_ch.ready) frames_seen++;
    if (!held_once && frames_seen >= 150) begin
      held_once = 1;
      hold_left = 200;
    end
    if ($urandom_range(0, 49) == 0) steady_sink = !steady_sink;
    if (hold_left > 0) begin
      hold_left--;
      px_ch.ready = 1'b0;
    end else if (steady_sink) begin
      px_ch.ready = 1'b1;
    end else begin
      px_ch.ready = (gap_len() == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (req_ch.valid && req_ch.ready) || (px_ch.valid && px_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_word(input nnfs_pkg::op_t op, input int x, input int y,
                           input logic [31:0] pix);
    int gap;
    gap = steady_src ? 0 : gap_len();
    if (gap > 0) begin
      @(negedge clk);
      req_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid = 1'b1;
    req_ch.operation = op;
    req_ch.coord_x = x[nnfs_pkg::COORD_W-1:0];
    req_ch.coord_y = y[nnfs_pkg::COORD_W-1:0];
    req_ch.pixel_in = pix;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (reads_in_flight != 0) @(posedge clk);
    // writes give no word back, let them clear the pipeline
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [nnfs_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [31:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
  endtask

  task automatic run_phase(input int fw, input int fh, input int iw, input int ih,
                           input logic [31:0] bg, input int n_ops);
    int ew, eh, fx;
    wait_idle();
    write_reg(nnfs_pkg::CFG_FRAME_WIDTH, fw);
    write_reg(nnfs_pkg::CFG_FRAME_HEIGHT, fh);
    write_reg(nnfs_pkg::CFG_IMAGE_WIDTH, iw);
    write_reg(nnfs_pkg::CFG_IMAGE_HEIGHT, ih);
    write_reg(nnfs_pkg::CFG_BACKGROUND, bg);
    write_reg(CFG_UNUSED_IDX, $urandom);
    @(negedge clk);
    cfg_we = 1'b0;
    steady_src = ($urandom_range(0, 3) == 0);
    ew = (iw > nnfs_pkg::MAX_IMAGE_WIDTH_DEF) ? nnfs_pkg::MAX_IMAGE_WIDTH_DEF : iw;
    eh = (ih > nnfs_pkg::MAX_IMAGE_HEIGHT_DEF) ? nnfs_pkg::MAX_IMAGE_HEIGHT_DEF : ih;
    fx = (fw > 4096) ? 4096 : ((fw == 0) ? 1 : fw);
    // fill the whole image so no read lands on a stale entry
    for (int y = 0; y < eh; y++)
      for (int x = 0; x < ew; x++)
        send_word(nnfs_pkg::OP_WRITE, x, y, $urandom);
    for (int i = 0; i < n_ops; i++) begin
      if ($urandom_range(0, 99) < 55) begin
        if ($urandom_range(0, 4) != 0)
          send_word(nnfs_pkg::OP_READ, $urandom_range(0, fx - 1),
                    $urandom_range(0, ((fh > 4096) ? 4096 : ((fh == 0) ? 1 : fh)) - 1), $urandom);
        else
          send_word(nnfs_pkg::OP_READ, $urandom_range(0, 4095), $urandom_range(0, 4095),
                    $urandom);
      end else if (ew > 0 && eh > 0 && $urandom_range(0, 3) != 0) begin
        send_word(nnfs_pkg::OP_WRITE, $urandom_range(0, ew - 1), $urandom_range(0, eh - 1),
                  $urandom);
      end else begin
        send_word(nnfs_pkg::OP_WRITE, $urandom_range(0, 4095), $urandom_range(0, 4095),
                  $urandom);
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    // reset window: 480x480 at left margin 80
    send_word(nnfs_pkg::OP_WRITE, 0, 0, 32'h0000_0000);
    send_word(nnfs_pkg::OP_WRITE, 255, 255, 32'hFFFF_FFFF);
    send_word(nnfs_pkg::OP_WRITE, 256, 0, 32'h1234_5678);
    send_word(nnfs_pkg::OP_WRITE, 4095, 4095, 32'hDEAD_BEEF);
    send_word(nnfs_pkg::OP_READ, 80, 0, 32'h0);
    send_word(nnfs_pkg::OP_READ, 559, 479, 32'hFFFF_FFFF);
    send_word(nnfs_pkg::OP_READ, 0, 0, 32'h0);
    send_word(nnfs_pkg::OP_READ, 79, 240, 32'h0);
    send_word(nnfs_pkg::OP_READ, 560, 240, 32'h0);
    send_word(nnfs_pkg::OP_READ, 639, 479, 32'h0);
    send_word(nnfs_pkg::OP_READ, 4095, 4095, 32'h0);
    send_word(nnfs_pkg::OP_READ, 100, 4095, 32'h0);

    run_phase(8191, 1, 256, 1, $urandom, 60);
    run_phase(0, 4096, 1, 256, 32'h0000_0000, 60);
    run_phase(4096, 300, 511, 1, 32'hFFFF_FFFF, 60);
    run_phase(1, 1, 0, 5, $urandom, 40);
    run_phase(100, 100, 3, 0, $urandom, 40);
    run_phase(1, 1, 2, 2, $urandom, 30);
    for (int p = 0; p < 8; p++)
      run_phase(($urandom_range(0, 7) == 0) ? 4096 : $urandom_range(1, 300),
                $urandom_range(1, 300), $urandom_range(1, 9), $urandom_range(1, 9),
                $urandom, 80);

    @(negedge clk);
    req_ch.valid = 1'b0;
    while (reads_in_flight != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
hdl/nnfs_pkg.sv
hdl/nnfs_in_if.sv
hdl/nnfs_out_if.sv
hdl/nnfs_ram.sv
hdl/nnfs_geom.sv
hdl/nearest_neighbor_fit_scaler_core.sv
tb/nnfs_scaler_checker.sv
tb/nearest_neighbor_fit_scaler_core_tb.sv
